// ===== rtl/pfv_pkg.sv =====
`default_nettype none
package pfv_pkg;

  localparam logic [7:0] CH_START = 8'h3b;  // ';'
  localparam logic [7:0] CH_END   = 8'h3a;  // ':'
  localparam logic [7:0] CH_X     = 8'h78;  // 'x'
  localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int unsigned MIN_LEN   = 3;
  localparam int unsigned OUT_CHARS = 7;
  // visible window over the store, deep enough for any MAX_CHARS up to 16
  localparam int unsigned VIS_DEPTH = 16;

  typedef logic [7:0] char_t;
  typedef char_t vis_t [VIS_DEPTH];

endpackage
`default_nettype wire

// ===== rtl/pfv_in_if.sv =====
`default_nettype none
interface pfv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/pfv_out_if.sv =====
`default_nettype none
interface pfv_out_if;
  logic       valid;
  logic       ready;
  logic       frame_status;
  logic [7:0] char_0;
  logic [7:0] char_1;
  logic [7:0] char_2;
  logic [7:0] char_3;
  logic [7:0] char_4;
  logic [7:0] char_5;
  logic [7:0] char_6;

  modport source (
    output valid, output frame_status,
    output char_0, output char_1, output char_2, output char_3,
    output char_4, output char_5, output char_6,
    input ready
  );
  modport sink (
    input valid, input frame_status,
    input char_0, input char_1, input char_2, input char_3,
    input char_4, input char_5, input char_6,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/pressure_frame_validator.sv =====
`default_nettype none
// Checks blood pressure frames of the form ';' text ':' (e.g. ";120x80:"), one
// received byte per word on rx_i, and gives a result word on res_o with
// frame_status 0 and the text padded with spaces, or frame_status 1 and all
// spaces. A result follows a closing ':', a stray ';' inside a frame, or any
// byte other than ';' outside a frame; other bytes give no result. Every byte
// is handled in the cycle it is accepted and its result is registered in the
// output register, so one byte is taken per clock cycle while rx_i.ready is
// high; it drops only while that register holds a result the sink has not taken.
// Up to MAX_CHARS bytes of text are kept; longer frames are flagged as errors.
module pressure_frame_validator #(
  parameter int unsigned MAX_CHARS = 7
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pfv_in_if.sink    rx_i,
  pfv_out_if.source res_o
);
  import pfv_pkg::*;

  localparam int unsigned CW = $clog2(MAX_CHARS + 2);
  localparam int unsigned IW = $clog2(MAX_CHARS);

  logic          in_frame_q, in_frame_d;
  logic [CW-1:0] count_q, count_d;
  logic [2:0]    x_idx_q, x_idx_d;
  char_t         store_q [MAX_CHARS];

  logic          out_valid_q, out_valid_d;
  logic          status_q;
  char_t         chars_q [OUT_CHARS];

  logic          accept;
  logic          emit;
  logic          emit_err;
  logic          store_we;
  logic          frame_ok;
  char_t         rx_b;
  vis_t          vis;

  assign rx_b   = rx_i.rx_byte;
  assign accept = rx_i.valid && rx_i.ready;
  assign rx_i.ready = !out_valid_q || res_o.ready;

  // positions not written in this frame read as space
  for (genvar i = 0; i < VIS_DEPTH; i++) begin : g_vis
    if (i < MAX_CHARS) begin : g_stored
      assign vis[i] = (count_q > CW'(i)) ? store_q[i] : CH_SPACE;
    end else begin : g_pad
      assign vis[i] = CH_SPACE;
    end
  end

  pfv_judge #(
    .MAX_CHARS (MAX_CHARS),
    .CW        (CW)
  ) u_judge (
    .count_i (count_q),
    .x_idx_i (x_idx_q),
    .vis_i   (vis),
    .ok_o    (frame_ok)
  );

  always_comb begin
    in_frame_d = in_frame_q;
    count_d    = count_q;
    x_idx_d    = x_idx_q;
    emit       = 1'b0;
    emit_err   = 1'b1;
    store_we   = 1'b0;
    if (accept) begin
      if (!in_frame_q) begin
        if (rx_b != CH_START) begin
          emit = 1'b1;
        end else begin
          in_frame_d = 1'b1;
          count_d    = '0;
          x_idx_d    = '0;
        end
      end else if (rx_b == CH_START) begin
        emit    = 1'b1;
        count_d = '0;
        x_idx_d = '0;
      end else if (rx_b == CH_END) begin
        emit       = 1'b1;
        emit_err   = !frame_ok;
        in_frame_d = 1'b0;
        count_d    = '0;
        x_idx_d    = '0;
      end else begin
        if (rx_b == CH_X) begin
          x_idx_d = (count_q > CW'(7)) ? 3'd7 : count_q[2:0];
        end
        store_we = (count_q < CW'(MAX_CHARS));
        if (count_q <= CW'(MAX_CHARS)) begin
          count_d = count_q + CW'(1);
        end
      end
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      count_q     <= '0;
      x_idx_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_frame_q  <= in_frame_d;
      count_q     <= count_d;
      x_idx_q     <= x_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[count_q[IW-1:0]] <= rx_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q <= emit_err;
      for (int i = 0; i < OUT_CHARS; i++) begin
        chars_q[i] <= emit_err ? CH_SPACE : vis[i];
      end
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.frame_status = status_q;
  assign res_o.char_0       = chars_q[0];
  assign res_o.char_1       = chars_q[1];
  assign res_o.char_2       = chars_q[2];
  assign res_o.char_3       = chars_q[3];
  assign res_o.char_4       = chars_q[4];
  assign res_o.char_5       = chars_q[5];
  assign res_o.char_6       = chars_q[6];

endmodule
`default_nettype wire

// ===== rtl/pfv_judge.sv =====
`default_nettype none
module pfv_judge #(
  parameter int unsigned MAX_CHARS = 7,
  parameter int unsigned CW = 4
) (
  input  logic [CW-1:0]   count_i,
  input  logic [2:0]      x_idx_i,
  input  pfv_pkg::vis_t   vis_i,
  output logic            ok_o
);
  import pfv_pkg::*;

  localparam int unsigned SW = ((CW > 3) ? CW : 3) + 1;

  logic [SW-1:0] n_ext;
  logic [SW-1:0] x_ext;
  logic          len_bad;
  logic          x_bad;
  logic          tail_bad;
  logic          minus_after;

  assign n_ext = SW'(count_i);
  assign x_ext = SW'(x_idx_i);

  assign len_bad  = (n_ext < SW'(MIN_LEN)) || (n_ext > SW'(MAX_CHARS));
  assign x_bad    = (x_idx_i == 3'd0) || (x_idx_i > 3'd3);
  assign tail_bad = (n_ext < x_ext + SW'(2)) || (n_ext > x_ext + SW'(4));

  // unwritten positions read as space in vis_i, so no extra range check
  always_comb begin
    case (x_idx_i)
      3'd1:    minus_after = (vis_i[2] == CH_MINUS);
      3'd2:    minus_after = (vis_i[3] == CH_MINUS);
      3'd3:    minus_after = (vis_i[4] == CH_MINUS);
      default: minus_after = 1'b0;
    endcase
  end

  assign ok_o = !len_bad && !x_bad && !tail_bad &&
                (vis_i[0] != CH_MINUS) && !minus_after;

endmodule
`default_nettype wire
